// ===== rtl/core/vtr_pkg.sv =====
// ----------------------------------------------------------------------------
// vtr_pkg
// Shared types and constants for the video timebase reducer.
// ----------------------------------------------------------------------------
package vtr_pkg;

    localparam int unsigned WideWidth = 64;
    localparam logic [31:0] UsPerS    = 32'd1000000;
    localparam logic [31:0] MsToUs    = 32'd1000;
    localparam logic [31:0] FallbackRateReset = 32'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD_START,
        ST_GCD_WAIT,
        ST_SCALE_START,
        ST_SCALE_WAIT,
        ST_RATE_START,
        ST_RATE_WAIT,
        ST_PER_START,
        ST_PER_WAIT,
        ST_OUT
    } vtr_state_t;

    // Divider operand selection
    typedef enum logic [2:0] {
        DSEL_GCD,
        DSEL_SCALE,
        DSEL_RATE,
        DSEL_PERIOD,
        DSEL_FALLBACK
    } vtr_dsel_t;

    typedef struct packed {
        logic      load;       // capture input item
        logic      div_start;
        vtr_dsel_t div_sel;
        logic      gcd_step;   // x <= y, y <= remainder
        logic      take_scale;
        logic      take_rate;
        logic      take_period;
        logic      set_fallback;
        logic      out_valid_set;
    } vtr_cmd_t;

    typedef struct packed {
        logic measured_ok;
        logic div_done;
        logic gcd_y_zero;
        logic out_busy;
    } vtr_status_t;

endpackage

// ===== rtl/core/video_timebase_reducer.sv =====
// ----------------------------------------------------------------------------
// video_timebase_reducer
// Reduced frame-rate fraction and frame period from frame count and duration.
// ----------------------------------------------------------------------------
// Channel   | Direction | Payload
// s_axis    | in        | frame_total[31:0], span_ms[95:32]
// m_axis    | out       | time_scale, time_rate, frame_period_us, from_measured
// cfg       | in        | fallback_rate
//
// Each item runs its divisions on the shared 64-bit radix-2 divider: one
// per gcd step (up to ~46), plus three more; a fallback item needs only
// the one division for its period.
// Reset clears the control state and sets fallback_rate to 1.
// A result waiting on m_axis holds s_axis_tready low until it is taken.
// ----------------------------------------------------------------------------
module video_timebase_reducer import vtr_pkg::*; (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // frame_total[31:0], span_ms[95:32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [103:0] m_axis_tdata,   // time_scale, time_rate, frame_period_us, from_measured
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [31:0]  cfg_data
);

    vtr_cmd_t    cmd;
    vtr_status_t status;

    assign cfg_ready = 1'b1;

    vtr_controller u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    vtr_datapath u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .frame_total   (s_axis_tdata[31:0]),
        .span_ms       (s_axis_tdata[95:32]),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== rtl/core/vtr_divider.sv =====
// ----------------------------------------------------------------------------
// vtr_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module vtr_divider import vtr_pkg::*; #(
    parameter int unsigned Width = WideWidth
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [Width-1:0] dividend,
    input  logic [Width-1:0] divisor,
    output logic             done,
    output logic [Width-1:0] quotient,
    output logic [Width-1:0] remainder
);

    localparam int unsigned CntWidth = $clog2(Width + 1);

    logic [Width-1:0]    quo_reg, quo_next;
    logic [Width-1:0]    rem_reg, rem_next;
    logic [Width-1:0]    dvs_reg, dvs_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [Width:0]      trial;
    logic [Width:0]      shifted;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[Width-1]};
        trial     = shifted - {1'b0, dvs_reg};
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CntWidth'(Width);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!trial[Width]) begin
                rem_next = trial[Width-1:0];
                quo_next = {quo_reg[Width-2:0], 1'b1};
            end else begin
                rem_next = shifted[Width-1:0];
                quo_next = {quo_reg[Width-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntWidth'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/core/vtr_datapath.sv =====
// ----------------------------------------------------------------------------
// vtr_datapath
// Operand registers, shared divider and result register.
// ----------------------------------------------------------------------------
module vtr_datapath import vtr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  vtr_cmd_t    cmd,
    output vtr_status_t status,
    input  logic [31:0] frame_total,
    input  logic [63:0] span_ms,
    input  logic        cfg_valid,
    input  logic [31:0] cfg_data,
    input  logic        m_axis_tready,
    output logic        m_axis_tvalid,
    output logic [103:0] m_axis_tdata
);

    logic [31:0] frames_reg;
    logic [31:0] dur_reg;
    logic [31:0] raw_reg;
    logic        ok_reg;
    logic [31:0] gx_reg, gy_reg;
    logic [31:0] scale_reg, rate_reg, period_reg;
    logic        meas_reg;
    logic        ovalid_reg;
    logic [31:0] fb_reg;
    logic [63:0] div_a, div_b, div_q, div_r;
    logic        div_done;
    logic [41:0] raw_full;
    logic [31:0] fb_rate;

    assign raw_full = {10'd0, frame_total} * {10'd0, MsToUs};
    assign fb_rate  = (fb_reg == '0) ? 32'd1 : fb_reg;

    always_comb begin
        case (cmd.div_sel)
            DSEL_GCD: begin
                div_a = {32'd0, gx_reg};
                div_b = {32'd0, gy_reg};
            end
            DSEL_SCALE: begin
                div_a = {32'd0, dur_reg};
                div_b = {32'd0, gx_reg};
            end
            DSEL_RATE: begin
                div_a = {32'd0, raw_reg};
                div_b = {32'd0, gx_reg};
            end
            DSEL_PERIOD: begin
                // dur*1000 + frames/2, dur < 2^32
                div_a = ({32'd0, dur_reg} << 10) - ({32'd0, dur_reg} << 4)
                      - ({32'd0, dur_reg} << 3) + {33'd0, frames_reg[31:1]};
                div_b = {32'd0, frames_reg};
            end
            default: begin
                div_a = {32'd0, UsPerS};
                div_b = {32'd0, fb_rate};
            end
        endcase
    end

    vtr_divider #(.Width(WideWidth)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ovalid_reg <= 1'b0;
            fb_reg     <= FallbackRateReset;
        end else begin
            if (cfg_valid) begin
                fb_reg <= cfg_data;
            end
            if (cmd.out_valid_set) begin
                ovalid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                ovalid_reg <= 1'b0;
            end
        end
        if (cmd.load) begin
            frames_reg <= frame_total;
            dur_reg    <= span_ms[31:0];
            raw_reg    <= raw_full[31:0];
            ok_reg     <= (frame_total != '0) && (span_ms != '0)
                          && (span_ms[63:32] == '0) && (raw_full[41:32] == '0);
            gx_reg     <= span_ms[31:0];
            gy_reg     <= raw_full[31:0];
        end
        if (cmd.gcd_step) begin
            gx_reg <= gy_reg;
            gy_reg <= div_r[31:0];
        end
        if (cmd.take_scale) begin
            scale_reg <= div_q[31:0];
        end
        if (cmd.take_rate) begin
            rate_reg <= div_q[31:0];
        end
        if (cmd.take_period) begin
            period_reg <= (div_q[63:32] != '0) ? '1 : div_q[31:0];
            meas_reg   <= 1'b1;
        end
        if (cmd.set_fallback) begin
            scale_reg  <= 32'd1;
            rate_reg   <= fb_rate;
            period_reg <= div_q[31:0];
            meas_reg   <= 1'b0;
        end
    end

    assign status.measured_ok = ok_reg;
    assign status.div_done    = div_done;
    assign status.gcd_y_zero  = (gy_reg == '0);
    assign status.out_busy    = ovalid_reg;
    assign m_axis_tvalid      = ovalid_reg;
    assign m_axis_tdata       = {7'd0, meas_reg, period_reg, rate_reg, scale_reg};

endmodule

// ===== rtl/core/vtr_controller.sv =====
// ----------------------------------------------------------------------------
// vtr_controller
// Sequences the gcd loop and the three divisions, or the one fallback division, on the shared divider.
// ----------------------------------------------------------------------------
module vtr_controller import vtr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  vtr_status_t status,
    output vtr_cmd_t    cmd
);

    vtr_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.div_sel   = DSEL_GCD;
        s_axis_tready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                // hold off new items while the result registers are on display
                s_axis_tready = !status.out_busy;
                if (s_axis_tvalid && !status.out_busy) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.measured_ok) begin
                    state_next = ST_GCD_START;
                end else begin
                    cmd.div_sel   = DSEL_FALLBACK;
                    cmd.div_start = 1'b1;
                    state_next    = ST_PER_WAIT;
                end
            end
            ST_GCD_START: begin
                // loop until y reaches zero; gx then holds the gcd (nonzero)
                if (status.gcd_y_zero) begin
                    state_next = ST_SCALE_START;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_GCD_WAIT;
                end
            end
            ST_GCD_WAIT: begin
                if (status.div_done) begin
                    cmd.gcd_step = 1'b1;
                    state_next   = ST_GCD_START;
                end
            end
            ST_SCALE_START: begin
                cmd.div_sel   = DSEL_SCALE;
                cmd.div_start = 1'b1;
                state_next    = ST_SCALE_WAIT;
            end
            ST_SCALE_WAIT: begin
                if (status.div_done) begin
                    cmd.take_scale = 1'b1;
                    state_next     = ST_RATE_START;
                end
            end
            ST_RATE_START: begin
                cmd.div_sel   = DSEL_RATE;
                cmd.div_start = 1'b1;
                state_next    = ST_RATE_WAIT;
            end
            ST_RATE_WAIT: begin
                if (status.div_done) begin
                    cmd.take_rate = 1'b1;
                    state_next    = ST_PER_START;
                end
            end
            ST_PER_START: begin
                cmd.div_sel   = DSEL_PERIOD;
                cmd.div_start = 1'b1;
                state_next    = ST_PER_WAIT;
            end
            ST_PER_WAIT: begin
                if (status.div_done) begin
                    if (status.measured_ok) begin
                        cmd.take_period = 1'b1;
                    end else begin
                        cmd.set_fallback = 1'b1;
                    end
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                // hold until the previous result has been taken
                if (!status.out_busy) begin
                    cmd.out_valid_set = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== verif/vtr_checker.sv =====
// ----------------------------------------------------------------------------
// vtr_checker
// Watches the input, result and register channels of the timebase reducer,
// predicts each result from the accepted inputs and compares field by field.
// ----------------------------------------------------------------------------
module vtr_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,   // frame_total[31:0], span_ms[95:32]
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [103:0] m_axis_tdata,   // scale, rate, period, from_measured
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [31:0]  cfg_data,
    output int           fail_count,
    output int           pending_count,
    output int           result_count,
    output int           measured_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] time_scale;
        logic [31:0] time_rate;
        logic [31:0] frame_period_us;
        logic        from_measured;
    } timebase_t;

    logic [31:0] nominal_rate;
    timebase_t   timebase_q[$];

    function automatic logic [31:0] common_divisor(logic [31:0] a, logic [31:0] b);
        logic [31:0] r;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        return (a != 0) ? a : 32'd1;
    endfunction

    function automatic timebase_t reduce_timebase(logic [31:0] frames, logic [63:0] dur,
                                                  logic [31:0] nominal);
        timebase_t   t;
        logic [63:0] raw;
        logic [63:0] us;
        logic [31:0] g;
        t.time_scale      = 32'd1;
        t.time_rate       = (nominal != 0) ? nominal : 32'd1;
        t.frame_period_us = 32'd1000000 / t.time_rate;
        t.from_measured   = 1'b0;
        raw = 64'(frames) * 64'd1000;
        if (frames != 0 && dur != 0 && dur <= 64'hFFFF_FFFF && raw <= 64'hFFFF_FFFF) begin
            g  = common_divisor(dur[31:0], raw[31:0]);
            us = (dur * 64'd1000 + 64'(frames / 2)) / 64'(frames);
            t.time_scale      = dur[31:0] / g;
            t.time_rate       = raw[31:0] / g;
            t.frame_period_us = (us > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : us[31:0];
            t.from_measured   = 1'b1;
        end
        return t;
    endfunction

    always @(posedge aclk) begin
        timebase_t want;
        timebase_t got;
        if (!aresetn) begin
            nominal_rate <= 32'd1;
            timebase_q.delete();
            fail_count     <= 0;
            pending_count  <= 0;
            result_count   <= 0;
            measured_count <= 0;
        end else begin
            if (cfg_valid && cfg_ready)
                nominal_rate <= cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                timebase_q.push_back(reduce_timebase(s_axis_tdata[31:0], s_axis_tdata[95:32],
                                                     nominal_rate));
            if (m_axis_tvalid && m_axis_tready) begin
                got = timebase_t'({m_axis_tdata[31:0], m_axis_tdata[63:32],
                                   m_axis_tdata[95:64], m_axis_tdata[96]});
                result_count <= result_count + 1;
                if (timebase_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = timebase_q.pop_front();
                    if (want.from_measured)
                        measured_count <= measured_count + 1;
                    if (want.time_scale != got.time_scale)
                        $display("%0t: time_scale expected %0d got %0d", $time,
                                 want.time_scale, got.time_scale);
                    if (want.time_rate != got.time_rate)
                        $display("%0t: time_rate expected %0d got %0d", $time,
                                 want.time_rate, got.time_rate);
                    if (want.frame_period_us != got.frame_period_us)
                        $display("%0t: frame_period_us expected %0d got %0d", $time,
                                 want.frame_period_us, got.frame_period_us);
                    if (want.from_measured != got.from_measured)
                        $display("%0t: from_measured expected %0d got %0d", $time,
                                 want.from_measured, got.from_measured);
                    if (want != got)
                        fail_count <= fail_count + 1;
                end
            end
            pending_count <= timebase_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives frame count and duration pairs into the timebase reducer: directed
// corner cases, then random sets, over several fallback rates and with random
// idling on both channels. A checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit = 20000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [103:0] m_axis_tdata;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [31:0]  cfg_data = '0;
    int           fail_count;
    int           pending_count;
    int           result_count;
    int           measured_count;
    int           idle_cycles = 0;
    int           sent_count = 0;
    bit           sink_steady = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    video_timebase_reducer dut (.*);

    vtr_checker checker_i (.*);

    // Randomly stall the result channel, except in the steady stretch.
    always @(negedge aclk)
        m_axis_tready <= sink_steady || ($urandom_range(99) >= 12);

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("timeout after %0d idle cycles", idle_cycles);
            $display("testbench: FAIL");
            $finish;
        end
    end

    // Leave tvalid high after a transfer; the next call replaces the data at
    // once or drops tvalid while it idles.
    task automatic send_timing(logic [31:0] frames, logic [63:0] dur, bit steady);
        if (!steady)
            while ($urandom_range(99) < 12) begin
                s_axis_tvalid <= 1'b0;
                @(negedge aclk);
            end
        s_axis_tdata  <= {dur, frames};
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        sent_count++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0 || m_axis_tvalid);
        repeat (4000) @(negedge aclk);
    endtask

    task automatic write_fallback(logic [31:0] rate);
        cfg_data  <= rate;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_frames();
        case ($urandom_range(3))
            0: return $urandom_range(4294967);       // measured range
            1: return $urandom_range(100);
            2: return $urandom;
            default: return 32'd1 << $urandom_range(31);
        endcase
    endfunction

    function automatic logic [63:0] rand_duration();
        case ($urandom_range(4))
            0: return 64'($urandom_range(100000));
            1: return 64'($urandom);
            2: return {$urandom, $urandom};
            3: return 64'd1 << $urandom_range(63);
            default: return 64'($urandom_range(3600000));
        endcase
    endfunction

    initial begin
        logic [31:0] rates[6] = '{32'd0, 32'd30, 32'd1000000, 32'd1000001,
                                  32'hFFFF_FFFF, 32'd25};
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed corners with the reset fallback rate.
        send_timing(32'd0, 64'd1000, 1'b0);
        send_timing(32'd30, 64'd0, 1'b0);
        send_timing(32'd0, 64'd0, 1'b0);
        send_timing(32'd30, 64'd1000, 1'b0);
        send_timing(32'd30000, 64'd1001000, 1'b0);
        send_timing(32'd1, 64'd1, 1'b0);
        send_timing(32'd1, 64'hFFFF_FFFF, 1'b0);
        send_timing(32'd30, 64'h1_0000_0000, 1'b0);
        send_timing(32'd30, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
        send_timing(32'd4294967, 64'd1, 1'b0);
        send_timing(32'd4294968, 64'd1, 1'b0);
        send_timing(32'hFFFF_FFFF, 64'd1000, 1'b0);
        send_timing(32'd4294967, 64'hFFFF_FFFF, 1'b0);
        send_timing(32'd2, 64'd3, 1'b0);
        send_timing(32'd3, 64'd5, 1'b0);
        send_timing(32'd60, 64'd1000, 1'b0);
        send_timing(32'd1000, 64'd1000, 1'b0);
        send_timing(32'd4294967, 64'd4294967, 1'b0);
        // Hold until every expected result has come.
        drain_results();

        foreach (rates[p]) begin
            write_fallback(rates[p]);
            sink_steady = (p == 2);
            for (int i = 0; i < 50; i++)
                send_timing(rand_frames(), rand_duration(), p == 2);
            drain_results();
        end

        $display("covered %0d items, %0d results (%0d measured), six fallback rates",
                 sent_count, result_count, measured_count);
        if (fail_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
